FILE: src/stpg_pkg.sv
// stpg_pkg: shared widths, codes and types for the step/dir pulse generator.
// No dependencies; imported by stpg_div and stepper_step_dir_pulse_generator_core.
package stpg_pkg;

	// field widths fixed by the register map and the stream words
	localparam int STEP_W    = 16;
	localparam int POS_CFG_W = 32;
	localparam int SPEED_W   = 24;
	localparam int FREQ_W    = 27;
	localparam int AMT_W     = 32;
	localparam int HALF_W    = 32;
	localparam int ERR_W     = 17;
	localparam int STATUS_W  = 3;
	localparam int POS_OUT_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	// default parameter values
	localparam int POS_WIDTH_DEF    = 32;
	localparam int RELOAD_WIDTH_DEF = 16;

	// stream word widths, padded to whole bytes
	localparam int S_DATA_W = ((AMT_W + SPEED_W + 7) / 8) * 8;
	localparam int M_FLD_W  = 4 + POS_OUT_W + ERR_W;
	localparam int M_DATA_W = ((M_FLD_W + 7) / 8) * 8;
	localparam int S_USER_W = 2;

	// shared divider: product of frequency and step size over twice the speed
	localparam int DIVIDEND_W = FREQ_W + STEP_W;
	localparam int DIVISOR_W  = SPEED_W + 1;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_MOVE  = 2'd1,
		REQ_START = 2'd2,
		REQ_STOP  = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK          = 3'd0,
		STS_NOT_RUNNING = 3'd1,
		STS_PARAM_ERR   = 3'd2,
		STS_INTERRUPTED = 3'd3,
		STS_IO_ERR      = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STEP_SIZE = 3'd0,
		CFG_POS_MIN   = 3'd1,
		CFG_POS_MAX   = 3'd2,
		CFG_SPD_LIMIT = 3'd3,
		CFG_TICK_FREQ = 3'd4,
		CFG_AXIS_REV  = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RLD,
		S_RLD_W,
		S_STP_W,
		S_NP1,
		S_NP2,
		S_PICK
	} state_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
		logic [DIVISOR_W-1:0]  remainder;
	} div_rsp_t;

endpackage

FILE: src/stpg_div.sv
// stpg_div: shared restoring divider, one quotient bit per cycle.
// Depends on stpg_pkg (widths, div_req_t, div_rsp_t).
module stpg_div
	import stpg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dsor_q;

	logic [DIVISOR_W:0] shifted;
	logic [DIVISOR_W:0] diff;

	// remainder stays below the divisor, so the top bit of diff is the borrow
	assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff    = shifted - {1'b0, dsor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIVIDEND_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q  <= req.dividend;
			rem_q  <= '0;
			dsor_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[DIVISOR_W]) begin
				rem_q <= diff[DIVISOR_W-1:0];
				quo_q <= {quo_q[DIVIDEND_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DIVISOR_W-1:0];
				quo_q <= {quo_q[DIVIDEND_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

FILE: src/stepper_step_dir_pulse_generator_core.sv
// stepper_step_dir_pulse_generator_core: top level of the step/dir pulse generator.
// Depends on stpg_pkg and stpg_div (shared divider).
//
// channel   dir  handshake                 word contents
// s_axis    in   s_axis_tvalid/tready      tuser: req_type; tdata: move_amount, move_speed
// m_axis    out  m_axis_tvalid/tready      tuser: status; tdata: pins, position, error
// cfg       in   cfg_valid/cfg_ready       cfg_index selects register, cfg_data value
//
// Tick, start and stop words finish in the cycle they are taken; the result sits in
// the output register, and a new word is taken in the same cycle as the old result
// leaves, so ticks run at one per clock while m_axis_tready stays high.
// A set-move word posts its result after the states S_RLD (launch), S_RLD_W and S_STP_W
// (divider waits: reload, then step count) and S_NP1, S_NP2, S_PICK (bound checks and
// the pick). Input is not ready meanwhile.
// Reset (arst_n low) parks the axis asleep, clockwise, at position 0.
// cfg is always ready; the user must make writes only while the block is idle; the block does not enforce this.
module stepper_step_dir_pulse_generator_core
	import stpg_pkg::*;
#(
	parameter int POS_WIDTH    = POS_WIDTH_DEF,
	parameter int RELOAD_WIDTH = RELOAD_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request words
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_DATA_W-1:0]  s_axis_tdata,  // [31:0] move_amount, [55:32] move_speed
	input  logic [S_USER_W-1:0]  s_axis_tuser,  // [1:0] req_type
	// result words
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [0] step_pin, [1] dir_pin, [2] sleep_pin_n, [3] running,
	// [35:4] position_now, [52:36] move_error, rest zero
	output logic [M_DATA_W-1:0]  m_axis_tdata,
	output logic [STATUS_W-1:0]  m_axis_tuser,  // [2:0] status
	// register writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	// bound arithmetic: position plus a move of up to 2^31 + 2^16, signed
	localparam int NP_W = ((POS_WIDTH > AMT_W) ? POS_WIDTH : AMT_W) + 3;

	// ---------------- configuration registers ----------------
	logic [STEP_W-1:0]    step_q;
	logic [POS_CFG_W-1:0] pmin_q;
	logic [POS_CFG_W-1:0] pmax_q;
	logic [SPEED_W-1:0]   slim_q;
	logic [FREQ_W-1:0]    freq_q;
	logic                 axrev_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_W'(1);
			pmin_q  <= '0;
			pmax_q  <= '0;
			slim_q  <= '0;
			freq_q  <= FREQ_W'(1);
			axrev_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_STEP_SIZE: step_q  <= cfg_data[STEP_W-1:0];
				CFG_POS_MIN:   pmin_q  <= cfg_data[POS_CFG_W-1:0];
				CFG_POS_MAX:   pmax_q  <= cfg_data[POS_CFG_W-1:0];
				CFG_SPD_LIMIT: slim_q  <= cfg_data[SPEED_W-1:0];
				CFG_TICK_FREQ: freq_q  <= cfg_data[FREQ_W-1:0];
				CFG_AXIS_REV:  axrev_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------- axis state ----------------
	state_t                  state_q, state_d;
	logic [POS_WIDTH-1:0]    pos_q, pos_d;
	logic [HALF_W-1:0]       half_q, half_d;
	logic [RELOAD_WIDTH-1:0] reload_q, reload_d;
	logic [RELOAD_WIDTH-1:0] cdown_q, cdown_d;
	logic                    running_q, running_d;
	logic                    sleeping_q, sleeping_d;
	logic                    phase_q, phase_d;
	logic                    dir_cw_q, dir_cw_d;
	logic [ERR_W-1:0]        err_q, err_d;

	// set-move working registers
	logic [DIVIDEND_W-1:0]   prod_q, prod_d;
	logic [SPEED_W-1:0]      speed_q, speed_d;
	logic [AMT_W-1:0]        absm_q, absm_d;
	logic                    neg_q, neg_d;
	logic [AMT_W-1:0]        s1_q, s1_d;
	logic [STEP_W-1:0]       a1_q, a1_d;
	logic [STEP_W-1:0]       a2_q, a2_d;
	logic signed [NP_W-1:0]  np1_q, np1_d;
	logic signed [NP_W-1:0]  np2_q, np2_d;
	logic                    ok1_q, ok1_d;

	// output register
	logic                    out_valid_q;
	logic                    load_out;
	status_t                 sts;
	status_t                 out_sts_q;
	logic [3:0]              out_pins_q;
	logic [POS_OUT_W-1:0]    out_pos_q;
	logic [ERR_W-1:0]        out_err_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	stpg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// request word fields
	logic [AMT_W-1:0]   in_amount;
	logic [SPEED_W-1:0] in_speed;
	logic               in_accept;

	assign in_amount     = s_axis_tdata[AMT_W-1:0];
	assign in_speed      = s_axis_tdata[AMT_W +: SPEED_W];
	assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// widened operands
	logic [POS_WIDTH-1:0]   step_pos;
	logic signed [NP_W-1:0] pos_ext, pmin_ext, pmax_ext, mag_ext, step_ext;
	logic [AMT_W:0]         steps;
	logic                   ok2, pick1;
	logic [ERR_W-1:0]       a1_e, a2_e;

	assign step_pos = POS_WIDTH'(step_q);
	assign pos_ext  = {{(NP_W-POS_WIDTH){pos_q[POS_WIDTH-1]}}, pos_q};
	assign pmin_ext = {{(NP_W-POS_CFG_W){pmin_q[POS_CFG_W-1]}}, pmin_q};
	assign pmax_ext = {{(NP_W-POS_CFG_W){pmax_q[POS_CFG_W-1]}}, pmax_q};
	// floor count times step size equals |amount| minus the remainder
	assign mag_ext  = NP_W'(absm_q - AMT_W'(a1_q));
	assign step_ext = NP_W'(step_q);
	assign ok2      = (np2_q >= pmin_ext) && (np2_q <= pmax_ext);
	// tie goes to the floor count
	assign pick1    = ok1_q && (!ok2 || (a1_q <= a2_q));
	assign steps    = pick1 ? {1'b0, s1_q} : ({1'b0, s1_q} + 1'b1);
	assign a1_e     = ERR_W'(a1_q);
	assign a2_e     = ERR_W'(a2_q);

	always_comb begin
		state_d    = state_q;
		pos_d      = pos_q;
		half_d     = half_q;
		reload_d   = reload_q;
		cdown_d    = cdown_q;
		running_d  = running_q;
		sleeping_d = sleeping_q;
		phase_d    = phase_q;
		dir_cw_d   = dir_cw_q;
		err_d      = err_q;
		prod_d     = prod_q;
		speed_d    = speed_q;
		absm_d     = absm_q;
		neg_d      = neg_q;
		s1_d       = s1_q;
		a1_d       = a1_q;
		a2_d       = a2_q;
		np1_d      = np1_q;
		np2_d      = np2_q;
		ok1_d      = ok1_q;
		load_out   = 1'b0;
		sts        = STS_OK;
		div_req.start    = 1'b0;
		div_req.dividend = prod_q;
		div_req.divisor  = {speed_q, 1'b0};

		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					case (req_t'(s_axis_tuser))
						REQ_TICK: begin
							load_out = 1'b1;
							if (!running_q || sleeping_q) begin
								sts = STS_NOT_RUNNING;
							end else if (cdown_q > RELOAD_WIDTH'(1)) begin
								cdown_d = cdown_q - 1'b1;
							end else begin
								cdown_d = reload_q;
								if (half_q <= HALF_W'(1)) begin
									running_d  = 1'b0;
									sleeping_d = 1'b1;
								end
								if (half_q != '0) begin
									half_d = half_q - 1'b1;
								end
								phase_d = !phase_q;
								// position moves on the rising step edge only
								if (!phase_q) begin
									pos_d = dir_cw_q ? (pos_q - step_pos) : (pos_q + step_pos);
								end
							end
						end
						REQ_MOVE: begin
							if ((in_speed == '0) || (in_speed > slim_q) || (step_q == '0)) begin
								load_out = 1'b1;
								sts      = STS_PARAM_ERR;
								half_d   = '0;
								cdown_d  = '0;
								reload_d = '0;
								err_d    = '0;
							end else begin
								prod_d  = DIVIDEND_W'(freq_q) * DIVIDEND_W'(step_q);
								speed_d = in_speed;
								neg_d   = in_amount[AMT_W-1];
								absm_d  = in_amount[AMT_W-1] ? (~in_amount + 1'b1) : in_amount;
								state_d = S_RLD;
							end
						end
						REQ_START: begin
							load_out = 1'b1;
							if ((half_q == '0) || (reload_q == '0)) begin
								sts = STS_PARAM_ERR;
							end else if (phase_q) begin
								sts = STS_NOT_RUNNING;
							end else begin
								sleeping_d = 1'b0;
								running_d  = 1'b1;
							end
						end
						REQ_STOP: begin
							load_out   = 1'b1;
							running_d  = 1'b0;
							sleeping_d = 1'b1;
							if ((half_q != '0) || (reload_q != '0)) begin
								sts = STS_INTERRUPTED;
							end else if (phase_q) begin
								phase_d = 1'b0;
								sts     = STS_IO_ERR;
							end
						end
						default: ;
					endcase
				end
			end
			S_RLD: begin
				div_req.start = 1'b1;
				state_d       = S_RLD_W;
			end
			S_RLD_W: begin
				if (div_rsp.done) begin
					if (|div_rsp.quotient[DIVIDEND_W-1:RELOAD_WIDTH]) begin
						reload_d = '1;
						cdown_d  = '1;
					end else begin
						reload_d = div_rsp.quotient[RELOAD_WIDTH-1:0];
						cdown_d  = div_rsp.quotient[RELOAD_WIDTH-1:0];
					end
					div_req.start    = 1'b1;
					div_req.dividend = DIVIDEND_W'(absm_q);
					div_req.divisor  = DIVISOR_W'(step_q);
					state_d          = S_STP_W;
				end
			end
			S_STP_W: begin
				if (div_rsp.done) begin
					s1_d    = div_rsp.quotient[AMT_W-1:0];
					a1_d    = div_rsp.remainder[STEP_W-1:0];
					state_d = S_NP1;
				end
			end
			S_NP1: begin
				np1_d   = neg_q ? (pos_ext - mag_ext) : (pos_ext + mag_ext);
				a2_d    = step_q - a1_q;
				state_d = S_NP2;
			end
			S_NP2: begin
				np2_d   = neg_q ? (np1_q - step_ext) : (np1_q + step_ext);
				ok1_d   = (np1_q >= pmin_ext) && (np1_q <= pmax_ext);
				state_d = S_PICK;
			end
			S_PICK: begin
				load_out = 1'b1;
				state_d  = S_IDLE;
				if (!ok1_q && !ok2) begin
					sts      = STS_PARAM_ERR;
					half_d   = '0;
					cdown_d  = '0;
					reload_d = '0;
					err_d    = '0;
				end else begin
					// half steps = 2 * count, saturating
					half_d = (|steps[AMT_W:AMT_W-1]) ? '1 : {steps[AMT_W-2:0], 1'b0};
					if (pick1) begin
						err_d = neg_q ? (ERR_W'(0) - a1_e) : a1_e;
					end else begin
						err_d = neg_q ? a2_e : (ERR_W'(0) - a2_e);
					end
					dir_cw_d = neg_q ? !axrev_q : axrev_q;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			half_q      <= '0;
			reload_q    <= '0;
			cdown_q     <= '0;
			running_q   <= 1'b0;
			sleeping_q  <= 1'b1;
			phase_q     <= 1'b0;
			dir_cw_q    <= 1'b1;
			err_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			pos_q      <= pos_d;
			half_q     <= half_d;
			reload_q   <= reload_d;
			cdown_q    <= cdown_d;
			running_q  <= running_d;
			sleeping_q <= sleeping_d;
			phase_q    <= phase_d;
			dir_cw_q   <= dir_cw_d;
			err_q      <= err_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working and result payload, no reset
	always_ff @(posedge clk) begin
		prod_q  <= prod_d;
		speed_q <= speed_d;
		absm_q  <= absm_d;
		neg_q   <= neg_d;
		s1_q    <= s1_d;
		a1_q    <= a1_d;
		a2_q    <= a2_d;
		np1_q   <= np1_d;
		np2_q   <= np2_d;
		ok1_q   <= ok1_d;
		if (load_out) begin
			out_sts_q  <= sts;
			out_pins_q <= {running_d, !sleeping_d, dir_cw_d, phase_d};
			out_pos_q  <= POS_OUT_W'(pos_d);
			out_err_q  <= err_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_sts_q;
	assign m_axis_tdata  = M_DATA_W'({out_err_q, out_pos_q, out_pins_q});

`ifndef SYNTHESIS
	a_run_awake: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> !sleeping_q)
		else $error("running while asleep");

	a_cdown_le_reload: assert property (@(posedge clk) disable iff (!arst_n)
		cdown_q <= reload_q)
		else $error("countdown above reload");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> ((state_q == S_RLD_W) || (state_q == S_STP_W)))
		else $error("divider finished outside a wait state");

	a_pick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PICK) |=> (out_valid_q && (state_q == S_IDLE)))
		else $error("set-move result not posted");
`endif

endmodule
